[sv/fifo_from_two_stacks_core_macros.svh]
// Assertion macros for the two-stack queue core.
`ifndef FIFO_FROM_TWO_STACKS_CORE_MACROS_SVH
`define FIFO_FROM_TWO_STACKS_CORE_MACROS_SVH

`ifndef SYNTH
`define FTS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");
`define FTS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define FTS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define FTS_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

[sv/fts_pkg.sv]
// Constants, status codes and port types shared by the two-stack queue core.
package fts_pkg;
    localparam int DEPTH  = 128;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam logic FUNC_ENQ = 1'b0;
    localparam logic FUNC_DEQ = 1'b1;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [DATA_W-1:0] wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } t_ram_req;
endpackage

[sv/fts_ram.sv]
// Stack storage: one write port and one read port with registered read data.
module fts_ram
    import fts_pkg::*;
(
    input  logic              i_clk,
    input  t_ram_req          i_req,
    output logic [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[sv/fifo_from_two_stacks_core.sv]
// Queue core: a FIFO of 32-bit values held in two stack memories.
// Enqueue: result in the cycle after acceptance; one item every cycle while i_ready.
// Dequeue from a non-empty output stack: top entry is read, then registered out.
// Dequeue with an empty output stack: the input stack of n entries is moved
// across first, one entry per cycle, then the top entry is popped and returned.
// Synchronous active-low reset empties both stacks; memories are not cleared.
`include "fifo_from_two_stacks_core_macros.svh"

module fifo_from_two_stacks_core
    import fts_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_func,
    input  logic signed [31:0] i_value_in,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_value_out,
    output logic [1:0]         o_status
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_XFER,
        S_POP,
        S_RESP
    } t_state;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_in_cnt, n_in_cnt;
    logic [CNT_W-1:0]   r_out_cnt, n_out_cnt;
    logic               r_wr_pend, n_wr_pend;
    logic               r_out_valid, n_out_valid;
    logic [DATA_W-1:0]  r_value_out, n_value_out;
    logic [1:0]         r_status, n_status;

    t_ram_req           in_req, out_req;
    logic [DATA_W-1:0]  in_rd_data, out_rd_data;
    logic [CNT_W-1:0]   in_cnt_dec, out_cnt_dec;
    logic               accept;
    logic               in_full, q_empty;

    assign in_cnt_dec  = r_in_cnt - CNT_W'(1);
    assign out_cnt_dec = r_out_cnt - CNT_W'(1);
    assign in_full     = (r_in_cnt == CNT_W'(DEPTH));
    assign q_empty     = (r_in_cnt == '0) && (r_out_cnt == '0);
    assign o_ready     = (r_state == S_IDLE) && (!r_out_valid || i_ready);
    assign accept      = i_valid && o_ready;

    always_comb begin
        n_state     = r_state;
        n_in_cnt    = r_in_cnt;
        n_out_cnt   = r_out_cnt;
        n_wr_pend   = 1'b0;
        n_out_valid = r_out_valid && !i_ready;
        n_value_out = r_value_out;
        n_status    = r_status;

        in_req.wr_en    = 1'b0;
        in_req.wr_addr  = r_in_cnt[ADDR_W-1:0];
        in_req.wr_data  = i_value_in;
        in_req.rd_en    = 1'b0;
        in_req.rd_addr  = in_cnt_dec[ADDR_W-1:0];
        out_req.wr_en   = 1'b0;
        out_req.wr_addr = r_out_cnt[ADDR_W-1:0];
        out_req.wr_data = in_rd_data;
        out_req.rd_en   = 1'b0;
        out_req.rd_addr = out_cnt_dec[ADDR_W-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_func == FUNC_ENQ) begin
                        n_out_valid = 1'b1;
                        n_value_out = '0;
                        if (in_full) begin
                            n_status = ST_FULL;
                        end else begin
                            n_status     = ST_OK;
                            in_req.wr_en = 1'b1;
                            n_in_cnt     = r_in_cnt + CNT_W'(1);
                        end
                    end else if (q_empty) begin
                        n_out_valid = 1'b1;
                        n_value_out = '0;
                        n_status    = ST_EMPTY;
                    end else if (r_out_cnt != '0) begin
                        out_req.rd_en = 1'b1;
                        n_out_cnt     = out_cnt_dec;
                        n_state       = S_RESP;
                    end else begin
                        n_state = S_XFER;
                    end
                end
            end
            S_XFER: begin
                if (r_in_cnt != '0) begin
                    in_req.rd_en = 1'b1;
                    n_in_cnt     = in_cnt_dec;
                    n_wr_pend    = 1'b1;
                end else begin
                    n_state = S_POP;
                end
                if (r_wr_pend) begin
                    out_req.wr_en = 1'b1;
                    n_out_cnt     = r_out_cnt + CNT_W'(1);
                end
            end
            S_POP: begin
                out_req.rd_en = 1'b1;
                n_out_cnt     = out_cnt_dec;
                n_state       = S_RESP;
            end
            S_RESP: begin
                n_out_valid = 1'b1;
                n_value_out = out_rd_data;
                n_status    = ST_OK;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_in_cnt    <= '0;
            r_out_cnt   <= '0;
            r_wr_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_in_cnt    <= n_in_cnt;
            r_out_cnt   <= n_out_cnt;
            r_wr_pend   <= n_wr_pend;
            r_out_valid <= n_out_valid;
        end
        r_value_out <= n_value_out;
        r_status    <= n_status;
    end

    fts_ram u_in_stack (
        .i_clk     (i_clk),
        .i_req     (in_req),
        .o_rd_data (in_rd_data)
    );

    fts_ram u_out_stack (
        .i_clk     (i_clk),
        .i_req     (out_req),
        .o_rd_data (out_rd_data)
    );

    assign o_valid     = r_out_valid;
    assign o_value_out = $signed(r_value_out);
    assign o_status    = r_status;

    `FTS_ASSERT_IMP(a_in_cnt_range, i_clk, i_rst_n, 1'b1, r_in_cnt <= CNT_W'(DEPTH))
    `FTS_ASSERT_IMP(a_out_cnt_range, i_clk, i_rst_n, 1'b1, r_out_cnt <= CNT_W'(DEPTH))
    `FTS_ASSERT_IMP(a_pop_nonempty, i_clk, i_rst_n, r_state == S_POP, r_out_cnt != '0)
    `FTS_ASSERT_IMP(a_empty_zero, i_clk, i_rst_n, o_valid && (o_status == ST_EMPTY), o_value_out == '0)
    `FTS_ASSERT_NXT(a_enq_count, i_clk, i_rst_n, accept && (i_func == FUNC_ENQ) && !in_full, r_in_cnt == $past(r_in_cnt) + CNT_W'(1))

endmodule

[verif/tb_top.sv]
// Self-checking testbench for the two-stack queue core: random and directed beats.
`timescale 1ns / 100ps

module tb_top
    import fts_pkg::*;
();

    localparam int HOLD_AT  = 250;
    localparam int HOLD_LEN = 500;
    localparam int CALM_LO  = 700;
    localparam int CALM_HI  = 850;
    localparam int LIMIT    = 400000;
    localparam int N_ITEMS  = 1300;

    typedef struct {
        logic              func;
        logic [DATA_W-1:0] value;
        bit                drain_first;
    } t_request;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic [1:0]        status;
    } t_answer;

    logic               i_clk      = 1'b0;
    logic               i_rst_n    = 1'b0;
    logic               i_valid    = 1'b0;
    logic               i_func     = FUNC_ENQ;
    logic signed [31:0] i_value_in = '0;
    logic               i_ready    = 1'b0;
    logic               o_ready;
    logic               o_valid;
    logic signed [31:0] o_value_out;
    logic [1:0]         o_status;

    t_request          pending[$];
    t_answer           answers[$];
    logic [DATA_W-1:0] in_stack [DEPTH];
    logic [DATA_W-1:0] out_stack[DEPTH];
    int                in_cnt    = 0;
    int                out_cnt   = 0;
    int                n_sent    = 0;
    int                n_results = 0;
    int                n_total   = 0;
    int                errors    = 0;
    int                cycles    = 0;
    int                hold_left = 0;
    bit                hold_done = 1'b0;
    logic              calm;
    logic              sink_hold;

    fifo_from_two_stacks_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_func      (i_func),
        .i_value_in  (i_value_in),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_value_out (o_value_out),
        .o_status    (o_status)
    );

    assign calm      = (n_sent >= CALM_LO) && (n_sent < CALM_HI);
    assign sink_hold = (hold_left != 0);

    function automatic t_answer queue_op(logic func, logic [DATA_W-1:0] val);
        t_answer a;
        a.value  = '0;
        a.status = ST_OK;
        if (func == FUNC_ENQ) begin
            if (in_cnt >= DEPTH) begin
                a.status = ST_FULL;
            end else begin
                in_stack[in_cnt] = val;
                in_cnt++;
            end
        end else if (in_cnt == 0 && out_cnt == 0) begin
            a.status = ST_EMPTY;
        end else begin
            if (out_cnt == 0) begin
                while (in_cnt > 0) begin
                    in_cnt--;
                    out_stack[out_cnt] = in_stack[in_cnt];
                    out_cnt++;
                end
            end
            out_cnt--;
            a.value = out_stack[out_cnt];
        end
        return a;
    endfunction

    function automatic logic [DATA_W-1:0] rand_value();
        case ($urandom_range(3))
            0: return DATA_W'($urandom_range(15)) - DATA_W'(8);
            1: return ($urandom_range(1) != 0) ? 32'h7fff_ffff : 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic add_beat(logic func, logic [DATA_W-1:0] value, bit drain_first = 1'b0);
        t_request r;
        r.func        = func;
        r.value       = value;
        r.drain_first = drain_first;
        pending.push_back(r);
    endtask

    task automatic add_run(logic func, int len, bit drain_first = 1'b0);
        for (int k = 0; k < len; k++) begin
            add_beat(func, rand_value(), drain_first && k == 0);
        end
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
        errors++;
    endtask

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge i_clk) begin : drive
        logic fire;
        bit   offer;
        t_request r;
        fire = i_valid && o_ready;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (fire) begin
                n_sent <= n_sent + 1;
            end
            if (!i_valid || fire) begin
                offer = pending.size() > 0 && (calm || sink_hold || $urandom_range(99) >= 37);
                if (offer && pending[0].drain_first && (fire || n_results != n_sent)) begin
                    offer = 1'b0;
                end
                if (offer) begin
                    r = pending.pop_front();
                    i_valid    <= 1'b1;
                    i_func     <= r.func;
                    i_value_in <= r.value;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (!hold_done && n_sent >= HOLD_AT) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_LEN;
            i_ready   <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_ready   <= 1'b0;
        end else begin
            i_ready <= calm || ($urandom_range(99) >= 37);
        end
    end

    always @(posedge i_clk) begin : watch
        t_answer want;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                n_results <= n_results + 1;
                if (answers.size() == 0) begin
                    report_mismatch("unexpected beat", o_value_out, '0);
                end else begin
                    want = answers.pop_front();
                    if (o_value_out !== want.value) begin
                        report_mismatch("value_out", o_value_out, want.value);
                    end
                    if (o_status !== want.status) begin
                        report_mismatch("status", 32'(o_status), 32'(want.status));
                    end
                end
            end
            if (i_valid && o_ready) begin
                answers.push_back(queue_op(i_func, i_value_in));
            end
        end
    end

    initial begin
        add_beat(FUNC_DEQ, $urandom);
        add_beat(FUNC_ENQ, 32'h7fff_ffff);
        add_beat(FUNC_ENQ, 32'h8000_0000);
        add_beat(FUNC_ENQ, 32'h0000_0000);
        add_beat(FUNC_ENQ, 32'hffff_ffff);
        add_beat(FUNC_ENQ, 32'h0000_0001);
        add_run(FUNC_DEQ, 3);
        add_beat(FUNC_ENQ, 32'h5555_5555);
        add_beat(FUNC_ENQ, 32'haaaa_aaaa);
        add_run(FUNC_DEQ, 4);
        add_beat(FUNC_DEQ, 32'hffff_ffff);

        add_run(FUNC_ENQ, DEPTH + 7, 1'b1);
        add_run(FUNC_DEQ, 1);
        add_run(FUNC_ENQ, DEPTH + 7);
        add_run(FUNC_DEQ, 3);
        add_run(FUNC_ENQ, 5);
        add_run(FUNC_DEQ, 2 * DEPTH + 4);

        while (pending.size() < N_ITEMS) begin
            case ($urandom_range(9)) inside
                [0:4]: begin
                    for (int k = $urandom_range(1, 40); k > 0; k--) begin
                        add_beat(($urandom_range(99) < 45) ? FUNC_DEQ : FUNC_ENQ, rand_value());
                    end
                end
                [5:6]: add_run(FUNC_ENQ, $urandom_range(100, DEPTH + 12));
                [7:8]: add_run(FUNC_DEQ, $urandom_range(20, 2 * DEPTH + 4));
                default: add_run(FUNC_DEQ, $urandom_range(1, 8), 1'b1);
            endcase
        end
        n_total = pending.size();

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(negedge i_clk); while (n_sent != n_total || n_results != n_total);
        repeat (2 * DEPTH + 10) @(negedge i_clk);

        if (errors == 0 && answers.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
